[rtl/wswm_pkg.sv]
// Shared types and constants for the weekly schedule window matcher.
// Used by wswm_regs and weekly_schedule_window_matcher; no dependencies.
package wswm_pkg;

    localparam int ENTRIES_DEF   = 8;
    localparam int ADDR_W        = 4;
    localparam int DAY_W         = 13;
    localparam int WRAP_W        = 5;
    localparam int YEAR_DAYS     = 365;
    localparam int YEAR_RECIP    = 2873;
    localparam int YEAR_RECIP_SH = 20;
    localparam int WEEK_DAYS     = 7;
    localparam int DAY_EVERY     = 8;
    localparam int SUNDAY_CHECK  = 0;
    localparam int SUNDAY_TABLE  = 7;
    localparam int MIN_PER_HOUR  = 60;
    localparam int RUN_WEEKS_RST = 52;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    localparam logic [1:0] REG_START_YEAR_DAY = 2'd0;
    localparam logic [1:0] REG_START_YEAR     = 2'd1;
    localparam logic [1:0] REG_RUN_WEEKS      = 2'd2;
    localparam logic [1:0] REG_RUN_FOREVER    = 2'd3;

    typedef struct packed {
        logic       func;
        logic [2:0] entry_index;
        logic       entry_enable;
        logic [3:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] span_hours;
        logic [5:0] span_minutes;
        logic [8:0] year_day;
        logic [7:0] year;
    } req_t;

    typedef struct packed {
        logic       in_range;
        logic [2:0] match_index;
        logic       expired;
    } rsp_t;

    typedef struct packed {
        logic       enable;
        logic [3:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] span_hours;
        logic [5:0] span_minutes;
    } entry_t;

    typedef struct packed {
        logic [8:0] start_year_day;
        logic [7:0] start_year;
        logic [9:0] run_weeks;
        logic       run_forever;
    } cfg_t;

endpackage

[rtl/wswm_regs.sv]
// APB-style configuration registers of the schedule matcher.
// Depends on wswm_pkg for the register codes and the cfg_t struct.
module wswm_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wswm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output wswm_pkg::cfg_t              cfg
);

    wswm_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_sel;
    logic           wr_en;

    assign reg_sel = paddr[wswm_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_year_day <= '0;
            cfg_reg.start_year     <= '0;
            cfg_reg.run_weeks      <= 10'(wswm_pkg::RUN_WEEKS_RST);
            cfg_reg.run_forever    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                wswm_pkg::REG_START_YEAR_DAY: cfg_reg.start_year_day <= pwdata[8:0];
                wswm_pkg::REG_START_YEAR:     cfg_reg.start_year     <= pwdata[7:0];
                wswm_pkg::REG_RUN_WEEKS:      cfg_reg.run_weeks      <= pwdata[9:0];
                wswm_pkg::REG_RUN_FOREVER:    cfg_reg.run_forever    <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            wswm_pkg::REG_START_YEAR_DAY: prdata = 32'(cfg_reg.start_year_day);
            wswm_pkg::REG_START_YEAR:     prdata = 32'(cfg_reg.start_year);
            wswm_pkg::REG_RUN_WEEKS:      prdata = 32'(cfg_reg.run_weeks);
            wswm_pkg::REG_RUN_FOREVER:    prdata = 32'(cfg_reg.run_forever);
        endcase
    end

endmodule

[rtl/weekly_schedule_window_matcher.sv]
// Top level of the weekly schedule window matcher: table memory, scan and expiry.
// Depends on wswm_pkg and wswm_regs.
//
// Usage:
//   Requests arrive on req_valid/req_ready with a req_t payload. A write request
//   (func = 0) loads one table entry in the cycle it is accepted and returns
//   nothing. A check request (func = 1) returns one rsp_t on rsp_valid/rsp_ready.
//   A check reads the table memory one entry per cycle while the expiry end day
//   is found by a two-step reciprocal multiply running alongside.
//   A check stops its scan at the first matching entry, and no new request is
//   taken until the check has handed its response to the output register.
//   A finished response sits in an output register; the next request is taken
//   while it waits. If the receiver stalls, a second check holds in its last
//   step until the output register frees up.
//   Reset marks every table entry as unwritten, which reads as disabled, and loads
//   the configuration defaults. The APB-style port sets the start day, start year,
//   run length and run-forever flag; the user, not the block, must hold these writes off while a check is in flight.
module weekly_schedule_window_matcher #(
    parameter int ENTRIES = wswm_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  wswm_pkg::req_t              req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output wswm_pkg::rsp_t              rsp_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wswm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);
    localparam int DW = wswm_pkg::DAY_W;
    localparam int WW = wswm_pkg::WRAP_W;
    localparam int PW = wswm_pkg::YEAR_RECIP_SH + WW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    wswm_pkg::cfg_t   cfg;
    wswm_pkg::req_t   cur_reg;
    wswm_pkg::rsp_t   rsp_reg;
    wswm_pkg::entry_t mem [ENTRIES];
    wswm_pkg::entry_t rd_data_reg;
    wswm_pkg::entry_t wr_entry;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [ENTRIES-1:0] valid_reg;
    logic               rsp_valid_reg;
    logic               req_acc;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   iss_cnt_reg;
    logic               evl_vld_reg;
    logic [IDX_W-1:0]   evl_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic               scan_done;

    logic [DW-1:0]      day_sum;
    logic [DW-1:0]      rem_reg;
    logic [PW-1:0]      recip_prod;
    logic               zero_reg;
    logic [WW-1:0]      wraps_reg;
    logic               div_k_reg;
    logic               div_run_reg;
    logic [DW-1:0]      end_day;
    logic [8:0]         end_year;
    logic               expired;
    logic               hit;
    logic               out_free;

    logic [3:0]         wday;
    logic [6:0]         min_sum;
    logic [6:0]         end_min;
    logic [1:0]         carry;
    logic [6:0]         end_hour;
    logic               en_ok;
    logic               day_ok;
    logic               start_ok;
    logic               end_ok;
    logic               covers;

    wswm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_acc   = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign wr_en   = req_acc && (req_data.func == wswm_pkg::FUNC_WRITE)
                     && (32'(req_data.entry_index) < ENTRIES);
    assign wr_addr = IDX_W'(req_data.entry_index);
    assign wr_entry = '{enable:       req_data.entry_enable,
                        day:          req_data.day,
                        hour:         req_data.hour,
                        minute:       req_data.minute,
                        span_hours:   req_data.span_hours,
                        span_minutes: req_data.span_minutes};

    assign rd_en   = (state_reg == S_BUSY) && (iss_cnt_reg != CNT_END) && !found_reg;
    assign rd_addr = iss_cnt_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_entry;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[wr_addr] <= 1'b1;
    end

    // entry match on the registered read data
    always_comb
    begin
        wday = (cur_reg.day == 4'(wswm_pkg::SUNDAY_CHECK))
               ? 4'(wswm_pkg::SUNDAY_TABLE) : cur_reg.day;
        min_sum = 7'(rd_data_reg.minute) + 7'(rd_data_reg.span_minutes);
        if (min_sum >= 7'(2 * wswm_pkg::MIN_PER_HOUR))
        begin
            carry   = 2'd2;
            end_min = min_sum - 7'(2 * wswm_pkg::MIN_PER_HOUR);
        end
        else if (min_sum >= 7'(wswm_pkg::MIN_PER_HOUR))
        begin
            carry   = 2'd1;
            end_min = min_sum - 7'(wswm_pkg::MIN_PER_HOUR);
        end
        else
        begin
            carry   = 2'd0;
            end_min = min_sum;
        end
        end_hour = 7'(rd_data_reg.hour) + 7'(rd_data_reg.span_hours) + 7'(carry);
        en_ok    = valid_reg[evl_idx_reg] && rd_data_reg.enable;
        day_ok   = (rd_data_reg.day == wday)
                   || (rd_data_reg.day == 4'(wswm_pkg::DAY_EVERY));
        start_ok = (cur_reg.hour > rd_data_reg.hour)
                   || ((cur_reg.hour == rd_data_reg.hour)
                       && (cur_reg.minute >= rd_data_reg.minute));
        end_ok   = (7'(cur_reg.hour) < end_hour)
                   || ((7'(cur_reg.hour) == end_hour) && (7'(cur_reg.minute) <= end_min));
        covers   = en_ok && day_ok && start_ok && end_ok;
    end

    assign scan_done = found_reg || ((iss_cnt_reg == CNT_END) && !evl_vld_reg);

    // expiry end day and year
    assign day_sum = DW'(cfg.start_year_day) + DW'(cfg.run_weeks) * DW'(wswm_pkg::WEEK_DAYS);
    assign recip_prod = PW'(rem_reg) * PW'(wswm_pkg::YEAR_RECIP);
    assign end_day = zero_reg ? '0 : rem_reg + DW'(1);
    assign end_year = 9'(cfg.start_year) + 9'(wraps_reg);
    assign expired = !cfg.run_forever && (DW'(cur_reg.year_day) > end_day)
                     && (9'(cur_reg.year) >= end_year);
    assign hit      = !expired && found_reg;
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc && (req_data.func == wswm_pkg::FUNC_CHECK))
                    state_next = S_BUSY;
            end
            S_BUSY:
            begin
                if (!div_run_reg && scan_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            iss_cnt_reg   <= '0;
            evl_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            div_run_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            evl_vld_reg <= rd_en;
            if (rd_en)
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            if ((state_reg == S_BUSY) && evl_vld_reg && !found_reg && covers)
                found_reg <= 1'b1;
            if (div_run_reg && !div_k_reg)
                div_run_reg <= 1'b0;
            if (req_acc && (req_data.func == wswm_pkg::FUNC_CHECK))
            begin
                iss_cnt_reg <= '0;
                found_reg   <= 1'b0;
                div_run_reg <= 1'b1;
            end
            if ((state_reg == S_DONE) && out_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
            cur_reg <= req_data;
        evl_idx_reg <= rd_addr;
        if ((state_reg == S_BUSY) && evl_vld_reg && !found_reg && covers)
            found_idx_reg <= evl_idx_reg;
        if (req_acc && (req_data.func == wswm_pkg::FUNC_CHECK))
        begin
            zero_reg  <= (day_sum == '0);
            rem_reg   <= (day_sum == '0) ? '0 : day_sum - DW'(1);
            wraps_reg <= '0;
            div_k_reg <= 1'b1;
        end
        else if (div_run_reg)
        begin
            if (div_k_reg)
                wraps_reg <= recip_prod[wswm_pkg::YEAR_RECIP_SH +: WW];
            else
                rem_reg <= rem_reg - DW'(wraps_reg) * DW'(wswm_pkg::YEAR_DAYS);
            div_k_reg <= 1'b0;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            rsp_reg.expired     <= expired;
            rsp_reg.in_range    <= hit;
            rsp_reg.match_index <= hit ? 3'(found_idx_reg) : 3'd0;
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for weekly_schedule_window_matcher: directed table, then random phases.
// Predicts check responses from a local copy of the schedule table and registers; directed rows may give theirs.
// Depends on wswm_pkg and the RTL top level only.
module testbench;
    import wswm_pkg::*;

    localparam rsp_t RSP_IDLE    = '0;
    localparam rsp_t RSP_EXPIRED = '{in_range: 1'b0, match_index: 3'd0, expired: 1'b1};
    localparam int   PHASES      = 6;
    localparam int   PHASE_ITEMS = 255;
    localparam int   HOLD_CYCLES = 400;
    localparam int   SETTLE      = 16;

    typedef struct {
        req_t item;
        bit   typed;
        rsp_t outcome;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_t                req_data = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_t                rsp_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    entry_t    slot_copy [ENTRIES_DEF];
    cfg_t      cfg_copy;
    rsp_t      verdict_q [$];
    plan_row_t plan_rows [$];
    cfg_t      phase_cfg [PHASES];

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int mismatches = 0;
    int sent = 0;
    int writes = 0;
    int responses = 0;
    int hits = 0;
    int expired_seen = 0;

    weekly_schedule_window_matcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    initial
    begin
        #(8 * 1500000);
        $display("FAILURE");
        $finish;
    end

    function automatic void flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    function automatic void run_end(output int end_day, output int end_year);
        int wraps;
        end_day = int'(cfg_copy.start_year_day) + int'(cfg_copy.run_weeks) * WEEK_DAYS;
        end_year = int'(cfg_copy.start_year);
        if (end_day > YEAR_DAYS)
        begin
            wraps = (end_day - 1) / YEAR_DAYS;
            end_day -= wraps * YEAR_DAYS;
            end_year += wraps;
        end
    endfunction

    function automatic rsp_t predict_verdict(req_t q);
        rsp_t   v;
        entry_t e;
        int     ed, ey, wd, hr, mn, mins, eh, em;
        v = RSP_IDLE;
        run_end(ed, ey);
        if (!cfg_copy.run_forever && int'(q.year_day) > ed && int'(q.year) >= ey)
            return RSP_EXPIRED;
        wd = (int'(q.day) == SUNDAY_CHECK) ? SUNDAY_TABLE : int'(q.day);
        hr = int'(q.hour);
        mn = int'(q.minute);
        for (int k = 0; k < ENTRIES_DEF; k++)
        begin
            e = slot_copy[k[2:0]];
            if (!e.enable)
                continue;
            if (int'(e.day) != wd && int'(e.day) != DAY_EVERY)
                continue;
            if (hr < int'(e.hour))
                continue;
            if (hr == int'(e.hour) && mn < int'(e.minute))
                continue;
            mins = int'(e.minute) + int'(e.span_minutes);
            eh = int'(e.hour) + int'(e.span_hours) + mins / MIN_PER_HOUR;
            em = mins % MIN_PER_HOUR;
            if (hr > eh)
                continue;
            if (hr == eh && mn > em)
                continue;
            v.in_range = 1'b1;
            v.match_index = k[2:0];
            return v;
        end
        return v;
    endfunction

    function automatic req_t wr_req(int idx, int en, int day, int hr, int mn, int sh, int sm);
        req_t q;
        q = '0;
        q.func = FUNC_WRITE;
        q.entry_index = idx[2:0];
        q.entry_enable = en[0];
        q.day = day[3:0];
        q.hour = hr[4:0];
        q.minute = mn[5:0];
        q.span_hours = sh[4:0];
        q.span_minutes = sm[5:0];
        return q;
    endfunction

    function automatic req_t ck_req(int day, int hr, int mn, int yd, int yr);
        req_t q;
        q = '0;
        q.func = FUNC_CHECK;
        q.day = day[3:0];
        q.hour = hr[4:0];
        q.minute = mn[5:0];
        q.year_day = yd[8:0];
        q.year = yr[7:0];
        return q;
    endfunction

    function automatic plan_row_t plan(req_t q, bit typed, rsp_t o);
        plan_row_t r;
        r.item = q;
        r.typed = typed;
        r.outcome = o;
        return r;
    endfunction

    function automatic req_t random_write();
        req_t q;
        q = wr_req($urandom_range(0, 7), ($urandom_range(0, 4) != 0), $urandom_range(1, 8),
                   $urandom_range(0, 23), $urandom_range(0, 59),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : $urandom_range(0, 3),
                   $urandom_range(0, 59));
        q.year_day = 9'($urandom);
        q.year = 8'($urandom);
        return q;
    endfunction

    function automatic req_t random_check();
        req_t   q;
        entry_t e;
        int     ed, ey, yr, yd, hr, mn, em;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        q = raw[$bits(req_t)-1:0];
        q.func = FUNC_CHECK;
        if ($urandom_range(0, 9) < 8)
        begin
            e = slot_copy[3'($urandom_range(0, ENTRIES_DEF - 1))];
            if (int'(e.day) == DAY_EVERY)
                q.day = 4'($urandom_range(0, 6));
            else if (int'(e.day) == SUNDAY_TABLE)
                q.day = 4'($urandom_range(0, 1) ? SUNDAY_CHECK : SUNDAY_TABLE);
            else
                q.day = e.day;
            hr = int'(e.hour) + $urandom_range(0, e.span_hours + 1) - $urandom_range(0, 1);
            em = (int'(e.minute) + int'(e.span_minutes)) % MIN_PER_HOUR;
            case ($urandom_range(0, 4))
                0: mn = int'(e.minute);
                1: mn = int'(e.minute) - 1;
                2: mn = em;
                3: mn = em + 1;
                default: mn = $urandom_range(0, 59);
            endcase
            q.hour = hr[4:0];
            q.minute = mn[5:0];
        end
        else if ($urandom_range(0, 1))
        begin
            q.day = 4'($urandom_range(0, 6));
            q.hour = 5'($urandom_range(0, 23));
            q.minute = 6'($urandom_range(0, 59));
        end
        run_end(ed, ey);
        yr = ey + $urandom_range(0, 3) - 1;
        if (yr > 255 || yr < 0 || $urandom_range(0, 7) == 0)
            yr = $urandom_range(0, 255);
        case ($urandom_range(0, 3))
            0: yd = ed + $urandom_range(0, 4) - 2;
            1, 2: yd = $urandom_range(0, YEAR_DAYS);
            default: yd = $urandom_range(0, 511);
        endcase
        if (yd < 0)
            yd = 0;
        q.year = yr[7:0];
        q.year_day = yd[8:0];
        return q;
    endfunction

    function automatic req_t random_request();
        int pick;
        logic [63:0] raw;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return random_write();
        if (pick < 9)
            return random_check();
        raw = {$urandom, $urandom};
        return raw[$bits(req_t)-1:0];
    endfunction

    function automatic logic [31:0] reg_mask(logic [1:0] ri);
        case (ri)
            REG_START_YEAR_DAY: return 32'h1FF;
            REG_START_YEAR:     return 32'hFF;
            REG_RUN_WEEKS:      return 32'h3FF;
            default:            return 32'h1;
        endcase
    endfunction

    function automatic logic [31:0] reg_image(logic [1:0] ri);
        case (ri)
            REG_START_YEAR_DAY: return 32'(cfg_copy.start_year_day);
            REG_START_YEAR:     return 32'(cfg_copy.start_year);
            REG_RUN_WEEKS:      return 32'(cfg_copy.run_weeks);
            default:            return 32'(cfg_copy.run_forever);
        endcase
    endfunction

    function automatic void cfg_store(logic [1:0] ri, logic [31:0] v);
        case (ri)
            REG_START_YEAR_DAY: cfg_copy.start_year_day = v[8:0];
            REG_START_YEAR:     cfg_copy.start_year = v[7:0];
            REG_RUN_WEEKS:      cfg_copy.run_weeks = v[9:0];
            default:            cfg_copy.run_forever = v[0];
        endcase
    endfunction

    function automatic logic [31:0] cfg_field(cfg_t c, logic [1:0] ri);
        case (ri)
            REG_START_YEAR_DAY: return 32'(c.start_year_day);
            REG_START_YEAR:     return 32'(c.start_year);
            REG_RUN_WEEKS:      return 32'(c.run_weeks);
            default:            return 32'(c.run_forever);
        endcase
    endfunction

    task automatic apb_access(input logic [1:0] ri, input bit wr, input logic [31:0] wd,
                              output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {ri, 2'b00};
        pwdata <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
    endtask

    task automatic verify_regs();
        logic [31:0] rd;
        logic [1:0]  ri;
        for (int i = 0; i < 4; i++)
        begin
            ri = i[1:0];
            apb_access(ri, 1'b0, 32'h0, rd);
            if (rd !== reg_image(ri))
                flag_mismatch("register readback", int'(reg_image(ri)), int'(rd));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_schedule(input cfg_t c, input bit junk);
        logic [31:0] rd, wv;
        logic [1:0]  ri;
        for (int i = 0; i < 4; i++)
        begin
            ri = i[1:0];
            wv = junk ? (($urandom & ~reg_mask(ri)) | cfg_field(c, ri)) : cfg_field(c, ri);
            apb_access(ri, 1'b1, wv, rd);
            cfg_store(ri, wv);
        end
        verify_regs();
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_request(input req_t item, input bit typed, input rsp_t given);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent++;
        if (item.func == FUNC_WRITE)
        begin
            writes++;
            if (int'(item.entry_index) < ENTRIES_DEF)
                slot_copy[item.entry_index] = entry_t'({item.entry_enable, item.day, item.hour,
                                                        item.minute, item.span_hours,
                                                        item.span_minutes});
        end
        else
            verdict_q.push_back(typed ? given : predict_verdict(item));
    endtask

    // response side: random stalls, plus one long hold on request
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if (!calm)
                    stall = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            responses++;
            if (verdict_q.size() == 0)
                flag_mismatch("response with nothing pending", -1, int'(rsp_data));
            else
            begin
                want = verdict_q.pop_front();
                if (want.in_range)
                    hits++;
                if (want.expired)
                    expired_seen++;
                if (rsp_data.in_range !== want.in_range)
                    flag_mismatch("in_range", int'(want.in_range), int'(rsp_data.in_range));
                if (rsp_data.match_index !== want.match_index)
                    flag_mismatch("match_index", int'(want.match_index),
                                  int'(rsp_data.match_index));
                if (rsp_data.expired !== want.expired)
                    flag_mismatch("expired", int'(want.expired), int'(rsp_data.expired));
            end
        end
    end

    initial
    begin
        for (int k = 0; k < ENTRIES_DEF; k++)
            slot_copy[k[2:0]] = '0;
        cfg_copy = '{start_year_day: 9'd0, start_year: 8'd0,
                     run_weeks: 10'(RUN_WEEKS_RST), run_forever: 1'b0};

        plan_rows.push_back(plan(ck_req(0, 0, 0, 0, 0), 1'b1, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(3, 12, 0, 365, 0), 1'b1, RSP_EXPIRED));
        plan_rows.push_back(plan(ck_req(15, 31, 63, 511, 255), 1'b1, RSP_EXPIRED));
        plan_rows.push_back(plan(wr_req(0, 1, 8, 9, 30, 1, 45), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(3, 9, 29, 10, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(3, 9, 30, 10, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(3, 10, 0, 10, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(3, 11, 15, 10, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(3, 11, 16, 10, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(wr_req(7, 1, 7, 23, 59, 31, 63), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(0, 31, 63, 100, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(wr_req(3, 0, 15, 0, 0, 23, 59), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(wr_req(2, 1, 1, 0, 0, 0, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(1, 0, 0, 5, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(1, 0, 1, 5, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(wr_req(1, 1, 8, 0, 0, 23, 59), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(1, 0, 0, 5, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(15, 12, 30, 200, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(0, 23, 59, 364, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(0, 12, 0, 365, 0), 1'b1, RSP_EXPIRED));
        plan_rows.push_back(plan(wr_req(1, 0, 8, 0, 0, 23, 59), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(6, 24, 0, 0, 0), 1'b0, RSP_IDLE));
        plan_rows.push_back(plan(ck_req(7, 23, 59, 1, 255), 1'b0, RSP_IDLE));

        phase_cfg[0] = '{start_year_day: 9'd100, start_year: 8'd120, run_weeks: 10'd10,
                         run_forever: 1'b0};
        phase_cfg[1] = '0;
        phase_cfg[2] = '{start_year_day: 9'd365, start_year: 8'd200, run_weeks: 10'd1023,
                         run_forever: 1'b0};
        phase_cfg[3] = '{start_year_day: 9'd300, start_year: 8'd255, run_weeks: 10'd0,
                         run_forever: 1'b1};
        phase_cfg[4] = '{start_year_day: 9'($urandom_range(0, YEAR_DAYS)),
                         start_year: 8'($urandom_range(90, 130)),
                         run_weeks: 10'($urandom_range(0, 120)), run_forever: 1'b0};
        phase_cfg[5] = '{start_year_day: 9'($urandom_range(0, YEAR_DAYS)),
                         start_year: 8'($urandom), run_weeks: 10'($urandom),
                         run_forever: 1'($urandom_range(0, 1))};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        verify_regs();

        foreach (plan_rows[i])
            send_request(plan_rows[i].item, plan_rows[i].typed, plan_rows[i].outcome);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            program_schedule(phase_cfg[p[2:0]], p >= 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                calm = (n >= 190 && n < 240);
                if (p == 0 && n == 60)
                    hold_request = 1'b1;
                send_request(random_request(), 1'b0, RSP_IDLE);
            end
        end
        calm = 1'b0;
        settle();
        repeat (20) @(posedge clk);

        $display("Ran %0d requests (%0d table writes) over %0d register settings.",
                 sent, writes, PHASES + 1);
        $display("Checked %0d responses: %0d in a window, %0d past the run end.",
                 responses, hits, expired_seen);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
